@@ rtl/lfuc_pkg.sv @@
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared types and constants of the LFU cache with LRU tie-break.
// ----------------------------------------------------------------------------
package lfuc_pkg;

  localparam int unsigned Capacity  = 16;
  localparam int unsigned CountBits = 16;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned CapRegW   = 5;
  localparam logic [CapRegW-1:0] CapReset = 5'd16;

  localparam logic OpGet = 1'b0;
  localparam logic OpSet = 1'b1;

  localparam logic [0:0] RegCapacity = 1'b0;

  typedef enum logic [1:0] {
    StIdle,
    StLookup,
    StUpdate,
    StOutput
  } state_e;

  typedef struct packed {
    logic load;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic set_op;
  } status_t;

endpackage

@@ rtl/lfuc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfuc_ctrl
// Controller: sequences load, lookup, update and result transfer.
// ----------------------------------------------------------------------------
module lfuc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lfuc_pkg::cmd_t   cmd_o
);

  lfuc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfuc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      lfuc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lfuc_pkg::StLookup;
        end
      end
      lfuc_pkg::StLookup: state_d = lfuc_pkg::StUpdate;
      lfuc_pkg::StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = lfuc_pkg::StOutput;
      end
      lfuc_pkg::StOutput: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = lfuc_pkg::StLookup;
          end else begin
            state_d = lfuc_pkg::StIdle;
          end
        end
      end
      default: state_d = lfuc_pkg::StIdle;
    endcase
  end

endmodule

@@ rtl/lfuc_dp.sv @@
// ----------------------------------------------------------------------------
// lfuc_dp
// Datapath: slot table, parallel key match, victim search and update.
// ----------------------------------------------------------------------------
module lfuc_dp #(
  parameter int unsigned Capacity  = lfuc_pkg::Capacity,
  parameter int unsigned CountBits = lfuc_pkg::CountBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfuc_pkg::cmd_t                cmd_i,
  input  logic                          op_i,
  input  logic [lfuc_pkg::KeyW-1:0]     key_i,
  input  logic [lfuc_pkg::KeyW-1:0]     val_i,
  input  logic [lfuc_pkg::CapRegW-1:0]  cap_reg_i,
  output logic                          found_o,
  output logic [lfuc_pkg::KeyW-1:0]     read_value_o,
  output logic                          evicted_o,
  output logic [lfuc_pkg::KeyW-1:0]     evicted_key_o
);

  localparam int unsigned IdxW   = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW   = $clog2(Capacity + 1);
  localparam int unsigned KW     = lfuc_pkg::KeyW;
  localparam int unsigned Leaves = 1 << IdxW;
  localparam logic [CountBits-1:0] CountMax = '1;

  logic [Capacity-1:0]  valid_q;
  logic [KW-1:0]        key_q  [Capacity];
  logic [KW-1:0]        data_q [Capacity];
  logic [CountBits-1:0] cnt_q  [Capacity];
  logic [IdxW-1:0]      rank_q [Capacity];
  logic [CntW-1:0]      occ_q;

  logic          op_q;
  logic [KW-1:0] in_key_q, in_val_q;

  logic            hit_q, full_q, hasv_q;
  logic [IdxW-1:0] hit_idx_q, vic_idx_q, free_idx_q;

  logic            found_q, ev_q;
  logic [KW-1:0]   rd_q, evk_q;

  // Match, victim and free-slot search over the slot table.
  logic            hit_c, hasv_c, hasf_c;
  logic [IdxW-1:0] hit_idx_c, vic_idx_c, free_idx_c;
  logic [CntW-1:0] cap_c;

  // Victim search tree: lowest count first, then the highest recency rank,
  // then the lower slot number.
  logic                 vt_v [2*Leaves];
  logic [CountBits-1:0] vt_c [2*Leaves];
  logic [IdxW-1:0]      vt_r [2*Leaves];
  logic [IdxW-1:0]      vt_i [2*Leaves];

  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    hasf_c     = 1'b0;
    free_idx_c = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (valid_q[i] && key_q[i] == in_key_q && !hit_c) begin
        hit_c     = 1'b1;
        hit_idx_c = IdxW'(i);
      end
      if (!valid_q[i] && !hasf_c) begin
        hasf_c     = 1'b1;
        free_idx_c = IdxW'(i);
      end
    end
    for (int n = 0; n < 2 * Leaves; n++) begin
      vt_v[n] = 1'b0;
      vt_c[n] = '0;
      vt_r[n] = '0;
      vt_i[n] = '0;
    end
    for (int i = 0; i < Capacity; i++) begin
      if (valid_q[i]) begin
        vt_v[Leaves+i] = 1'b1;
        vt_c[Leaves+i] = cnt_q[i];
        vt_r[Leaves+i] = rank_q[i];
      end
      vt_i[Leaves+i] = IdxW'(i);
    end
    for (int n = Leaves - 1; n >= 1; n--) begin
      if (vt_v[2*n+1] && (!vt_v[2*n] || vt_c[2*n+1] < vt_c[2*n] ||
          (vt_c[2*n+1] == vt_c[2*n] && vt_r[2*n+1] > vt_r[2*n]))) begin
        vt_v[n] = vt_v[2*n+1];
        vt_c[n] = vt_c[2*n+1];
        vt_r[n] = vt_r[2*n+1];
        vt_i[n] = vt_i[2*n+1];
      end else begin
        vt_v[n] = vt_v[2*n];
        vt_c[n] = vt_c[2*n];
        vt_r[n] = vt_r[2*n];
        vt_i[n] = vt_i[2*n];
      end
    end
    hasv_c    = vt_v[1];
    vic_idx_c = vt_i[1];
    if (32'(cap_reg_i) > Capacity) begin
      cap_c = CntW'(Capacity);
    end else begin
      cap_c = CntW'(cap_reg_i);
    end
  end

  logic capz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      in_key_q <= key_i;
      in_val_q <= val_i;
    end
    hit_q      <= hit_c;
    hit_idx_q  <= hit_idx_c;
    hasv_q     <= hasv_c;
    vic_idx_q  <= vic_idx_c;
    free_idx_q <= free_idx_c;
    full_q     <= (32'(occ_q) >= 32'(cap_c)) || !hasf_c;
    capz_q     <= (cap_c == '0);
  end

  // Update step.
  logic            do_hit, do_ins, do_ev;
  logic [IdxW-1:0] tgt, old_rank;

  always_comb begin
    do_hit   = hit_q && (op_q == lfuc_pkg::OpGet || !capz_q);
    do_ins   = !hit_q && op_q == lfuc_pkg::OpSet && !capz_q;
    do_ev    = do_ins && full_q && hasv_q;
    tgt      = do_hit ? hit_idx_q : (do_ev ? vic_idx_q : free_idx_q);
    old_rank = rank_q[tgt];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else if (cmd_i.update && do_ins && (do_ev || !full_q)) begin
      valid_q[tgt] <= 1'b1;
      if (!do_ev) begin
        occ_q <= occ_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      found_q <= hit_q;
      rd_q    <= (op_q == lfuc_pkg::OpSet) ? '0 : (hit_q ? data_q[hit_idx_q] : '1);
      ev_q    <= do_ev;
      evk_q   <= do_ev ? key_q[vic_idx_q] : '0;
      for (int i = 0; i < Capacity; i++) begin
        if (do_hit) begin
          if (IdxW'(i) == tgt) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && rank_q[i] < old_rank) begin
            rank_q[i] <= rank_q[i] + IdxW'(1);
          end
        end else if (do_ins && (do_ev || !full_q)) begin
          if (IdxW'(i) == tgt) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (!do_ev || rank_q[i] < old_rank)) begin
            rank_q[i] <= rank_q[i] + IdxW'(1);
          end
        end
      end
      if (do_hit) begin
        if (cnt_q[tgt] != CountMax) begin
          cnt_q[tgt] <= cnt_q[tgt] + CountBits'(1);
        end
        if (op_q == lfuc_pkg::OpSet) begin
          data_q[tgt] <= in_val_q;
        end
      end else if (do_ins && (do_ev || !full_q)) begin
        key_q[tgt]  <= in_key_q;
        data_q[tgt] <= in_val_q;
        cnt_q[tgt]  <= CountBits'(1);
      end
    end
  end

  assign found_o       = found_q;
  assign read_value_o  = rd_q;
  assign evicted_o     = ev_q;
  assign evicted_key_o = evk_q;

endmodule

@@ rtl/lfu_cache_lru_tiebreak.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// LFU key-value store with least-recently-used tie-break among equal counts.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata: operation, lookup_key, write_value
// m_axis    out        tdata: found, read_value, evicted, evicted_key
// apb       in         register 0 at 0x0: capacity_in_use
//
// Each item passes through load, table search and update, then the output handshake.
// The next item is accepted in the cycle its predecessor's result transfers.
// Reset clears the valid marks and occupancy; capacity_in_use resets to 16.
// A stalled result holds the block; stored entries are not touched meanwhile.
module lfu_cache_lru_tiebreak #(
  parameter int unsigned Capacity  = lfuc_pkg::Capacity,
  parameter int unsigned CountBits = lfuc_pkg::CountBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // operation, lookup_key, write_value, pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,   // found, read_value, evicted, evicted_key, pad
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [lfuc_pkg::CapRegW-1:0] cap_q;
  lfuc_pkg::cmd_t cmd;
  logic found, evicted;
  logic [31:0] rd, evk;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lfuc_pkg::CapReset;
    end else if (psel && penable && pwrite && paddr == {lfuc_pkg::RegCapacity, 2'b00}) begin
      cap_q <= pwdata[lfuc_pkg::CapRegW-1:0];
    end
  end

  assign prdata = (paddr == {lfuc_pkg::RegCapacity, 2'b00}) ? 32'(cap_q) : '0;

  lfuc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  lfuc_dp #(.Capacity(Capacity), .CountBits(CountBits)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .op_i         (s_axis_tdata[0]),
    .key_i        (s_axis_tdata[32:1]),
    .val_i        (s_axis_tdata[64:33]),
    .cap_reg_i    (cap_q),
    .found_o      (found),
    .read_value_o (rd),
    .evicted_o    (evicted),
    .evicted_key_o(evk)
  );

  assign m_axis_tdata = {6'b0, evk, evicted, rd, found};

endmodule

@@ rtl/lfuc_checker.sv @@
// ----------------------------------------------------------------------------
// lfuc_checker
// Port-level checks of the LFU cache, bound to the top level.
// ----------------------------------------------------------------------------
module lfuc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid ##1 !m_axis_tvalid ##1 m_axis_tvalid)
    else $error("result not produced three cycles after accept");

  a_no_evict_on_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[0] == 1'b0)
    else $error("eviction reported with found set");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_evk_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[33] |-> m_axis_tdata[65:34] == 32'd0)
    else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_lru_tiebreak lfuc_checker u_lfuc_checker (.*);
